[hw/rtl/mbp_pkg.sv]
// Package for the Mandelbrot membership pixel block.
// Holds the word types, the configuration register map, and the fixed-point helpers.
// It depends on nothing else. Every other file of the block uses it.
package mbp_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_BITS  = 32;
    localparam int BAIL_BITS  = 31;
    localparam int ITER_BITS  = 16;
    localparam int IDX_BITS   = 3;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int PRE_BITS   = COORD_BITS + 2 + WORD_BITS;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic signed [WORD_BITS-1:0] RST_X_BEGIN = -32'sd536870912;
    localparam logic signed [WORD_BITS-1:0] RST_X_STEP  = 32'sd786432;
    localparam logic signed [WORD_BITS-1:0] RST_Y_BEGIN = -32'sd402653184;
    localparam logic signed [WORD_BITS-1:0] RST_Y_STEP  = 32'sd786432;
    localparam logic [BAIL_BITS-1:0]        RST_BAILOUT = 31'd1073741824;
    localparam logic [ITER_BITS-1:0]        RST_MAX_ITER = 16'd255;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_X_BEGIN  = 3'd0,
        CFG_X_STEP   = 3'd1,
        CFG_Y_BEGIN  = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_BAILOUT  = 3'd4,
        CFG_MAX_ITER = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
    } t_pixel;

    typedef struct packed {
        logic                  in_set;
        logic [COORD_BITS-1:0] out_column;
        logic [COORD_BITS-1:0] out_row;
    } t_result;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] x_begin;
        logic signed [WORD_BITS-1:0] x_step;
        logic signed [WORD_BITS-1:0] y_begin;
        logic signed [WORD_BITS-1:0] y_step;
        logic [BAIL_BITS-1:0]        bailout_level;
        logic [ITER_BITS-1:0]        iter_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul_c;
        logic add_c;
        logic square;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic escaped;
    } t_dp_sts;

    // Clamps a signed value to the 32-bit word range.
    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [WORD_BITS-1:0] res;
        if (v[PROD_BITS-1:WORD_BITS-1] == {(PROD_BITS-WORD_BITS+1){v[PROD_BITS-1]}}) begin
            res = v[WORD_BITS-1:0];
        end else if (v[PROD_BITS-1]) begin
            res = WORD_MIN;
        end else begin
            res = WORD_MAX;
        end
        return res;
    endfunction

endpackage

[hw/rtl/mbp_cfg.sv]
// Configuration register file of the Mandelbrot membership pixel block.
// Holds the six coordinate and iteration registers written through the plain write port.
// Depends on mbp_pkg.
module mbp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mbp_pkg::IDX_BITS-1:0] i_cfg_index,
    input  logic [mbp_pkg::WORD_BITS-1:0] i_cfg_data,
    output mbp_pkg::t_cfg                o_cfg
);
    import mbp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_BEGIN:  n_cfg.x_begin        = i_cfg_data;
                CFG_X_STEP:   n_cfg.x_step         = i_cfg_data;
                CFG_Y_BEGIN:  n_cfg.y_begin        = i_cfg_data;
                CFG_Y_STEP:   n_cfg.y_step         = i_cfg_data;
                CFG_BAILOUT:  n_cfg.bailout_level  = i_cfg_data[BAIL_BITS-1:0];
                CFG_MAX_ITER: n_cfg.iter_limit     = i_cfg_data[ITER_BITS-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_begin        <= RST_X_BEGIN;
            r_cfg.x_step         <= RST_X_STEP;
            r_cfg.y_begin        <= RST_Y_BEGIN;
            r_cfg.y_step         <= RST_Y_STEP;
            r_cfg.bailout_level  <= RST_BAILOUT;
            r_cfg.iter_limit     <= RST_MAX_ITER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/mbp_dp.sv]
// Datapath of the Mandelbrot membership pixel block.
// Forms the point c, then squares z with three multipliers and tests escape.
// Depends on mbp_pkg; driven by commands from mbp_ctrl.
module mbp_dp (
    input  logic                          i_clk,
    input  mbp_pkg::t_cfg                 i_cfg,
    input  mbp_pkg::t_pixel               i_pixel,
    input  mbp_pkg::t_dp_cmd              i_cmd,
    output mbp_pkg::t_dp_sts              o_sts,
    output logic [mbp_pkg::COORD_BITS-1:0] o_column,
    output logic [mbp_pkg::COORD_BITS-1:0] o_row
);
    import mbp_pkg::*;

    logic [COORD_BITS-1:0]        r_col;
    logic [COORD_BITS-1:0]        r_row;
    logic signed [PRE_BITS-1:0]   r_pre_re;
    logic signed [PRE_BITS-1:0]   r_pre_im;
    logic signed [WORD_BITS-1:0]  r_c_re;
    logic signed [WORD_BITS-1:0]  r_c_im;
    logic signed [WORD_BITS-1:0]  r_zr;
    logic signed [WORD_BITS-1:0]  r_zi;
    logic signed [PROD_BITS-1:0]  r_p_rr;
    logic signed [PROD_BITS-1:0]  r_p_ii;
    logic signed [PROD_BITS-1:0]  r_p_ri;

    logic [COORD_BITS:0]          col_inc;
    logic signed [PRE_BITS:0]     sum_re;
    logic signed [PRE_BITS:0]     sum_im;
    logic signed [WORD_BITS-1:0]  rr;
    logic signed [WORD_BITS-1:0]  ii;
    logic signed [WORD_BITS-1:0]  ri;
    logic signed [WORD_BITS:0]    norm;
    logic signed [WORD_BITS+1:0]  zr_sum;
    logic signed [WORD_BITS+1:0]  zi_sum;
    logic signed [WORD_BITS-1:0]  n_zr;
    logic signed [WORD_BITS-1:0]  n_zi;

    assign col_inc = {1'b0, r_col} + {{COORD_BITS{1'b0}}, 1'b1};
    assign sum_re  = {i_cfg.x_begin[WORD_BITS-1], {(PRE_BITS-WORD_BITS){i_cfg.x_begin[WORD_BITS-1]}},
                      i_cfg.x_begin} + {r_pre_re[PRE_BITS-1], r_pre_re};
    assign sum_im  = {i_cfg.y_begin[WORD_BITS-1], {(PRE_BITS-WORD_BITS){i_cfg.y_begin[WORD_BITS-1]}},
                      i_cfg.y_begin} + {r_pre_im[PRE_BITS-1], r_pre_im};

    assign rr = sat_word(r_p_rr >>> FRAC_BITS);
    assign ii = sat_word(r_p_ii >>> FRAC_BITS);
    assign ri = sat_word(r_p_ri >>> FRAC_BITS);

    assign norm   = {rr[WORD_BITS-1], rr} + {ii[WORD_BITS-1], ii};
    assign zr_sum = {{2{rr[WORD_BITS-1]}}, rr} - {{2{ii[WORD_BITS-1]}}, ii}
                  + {{2{r_c_re[WORD_BITS-1]}}, r_c_re};
    assign zi_sum = {ri[WORD_BITS-1], ri, 1'b0} + {{2{r_c_im[WORD_BITS-1]}}, r_c_im};
    assign n_zr   = sat_word({{(PROD_BITS-WORD_BITS-2){zr_sum[WORD_BITS+1]}}, zr_sum});
    assign n_zi   = sat_word({{(PROD_BITS-WORD_BITS-2){zi_sum[WORD_BITS+1]}}, zi_sum});

    assign o_sts.escaped = !(norm < $signed({2'b00, i_cfg.bailout_level}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_pixel.column;
            r_row <= i_pixel.row;
        end
        if (i_cmd.mul_c) begin
            r_pre_re <= $signed({1'b0, col_inc}) * i_cfg.x_step;
            r_pre_im <= $signed({2'b00, r_row}) * i_cfg.y_step;
        end
        if (i_cmd.add_c) begin
            r_c_re <= sat_word({{(PROD_BITS-PRE_BITS-1){sum_re[PRE_BITS]}}, sum_re});
            r_c_im <= sat_word({{(PROD_BITS-PRE_BITS-1){sum_im[PRE_BITS]}}, sum_im});
            r_zr   <= '0;
            r_zi   <= '0;
        end
        if (i_cmd.square) begin
            r_p_rr <= r_zr * r_zr;
            r_p_ii <= r_zi * r_zi;
            r_p_ri <= r_zr * r_zi;
        end
        if (i_cmd.update) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
        end
    end

    assign o_column = r_col;
    assign o_row    = r_row;

endmodule

[hw/rtl/mbp_ctrl.sv]
// Controller of the Mandelbrot membership pixel block.
// Sequences setup and the square and update steps of each pass, and counts passes.
// Depends on mbp_pkg; drives mbp_dp through command and status structs.
module mbp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [mbp_pkg::ITER_BITS-1:0] i_iter_limit,
    input  mbp_pkg::t_dp_sts              i_sts,
    output mbp_pkg::t_dp_cmd              o_cmd,
    output logic                          busy,
    output logic                          o_valid,
    output logic                          o_in_set
);
    import mbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL_C  = 5'b00010,
        S_ADD_C  = 5'b00100,
        S_SQUARE = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [ITER_BITS-1:0]  r_pass;
    logic [ITER_BITS-1:0]  n_pass;
    logic                  r_valid;
    logic                  n_valid;
    logic                  r_in_set;
    logic                  n_in_set;

    always_comb begin
        n_state  = r_state;
        n_pass   = r_pass;
        n_valid  = 1'b0;
        n_in_set = r_in_set;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    n_state = S_MUL_C;
                end
            end
            S_MUL_C: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_ADD_C;
            end
            S_ADD_C: begin
                o_cmd.add_c = 1'b1;
                n_pass      = '0;
                n_state     = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_sts.escaped) begin
                    n_valid  = 1'b1;
                    n_in_set = 1'b0;
                    n_state  = S_IDLE;
                end else if (r_pass == i_iter_limit) begin
                    n_valid  = 1'b1;
                    n_in_set = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_pass  = r_pass + 1'b1;
                    n_state = S_SQUARE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass   <= '0;
            r_valid  <= 1'b0;
            r_in_set <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass   <= n_pass;
            r_valid  <= n_valid;
            r_in_set <= n_in_set;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_in_set = r_in_set;

endmodule

[hw/rtl/mandelbrot_membership_pixel.sv]
// Mandelbrot membership pixel block: one pixel word in, one result word out.
// The result strobe is registered and rises after the multiply and add setup steps and P passes,
// where P is the number of passes made (up to the iteration limit plus one); each pass is a square
// step then an update step. One pixel is in flight at a time; a new start is taken in the cycle
// the result is shown. The receiver cannot stall the block.
// Synchronous active-low reset returns to idle and loads the register reset values.
module mandelbrot_membership_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mbp_pkg::t_pixel               i_pixel,
    output logic                          o_valid,
    output mbp_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [mbp_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [mbp_pkg::WORD_BITS-1:0] i_cfg_data
);
    import mbp_pkg::*;

    t_cfg                  cfg;
    t_dp_cmd               cmd;
    t_dp_sts               sts;
    logic                  in_set;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    mbp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbp_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_iter_limit     (cfg.iter_limit),
        .i_sts            (sts),
        .o_cmd            (cmd),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_in_set         (in_set)
    );

    mbp_dp u_dp (
        .i_clk    (i_clk),
        .i_cfg    (cfg),
        .i_pixel  (i_pixel),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_column (col),
        .o_row    (row)
    );

    assign o_result.in_set     = in_set;
    assign o_result.out_column = col;
    assign o_result.out_row    = row;

endmodule

[hw/rtl/mbp_chk.sv]
// Port-level checker for the Mandelbrot membership pixel block.
// Watches the start, busy and result strobe over time, and the result word; bound to the top level below.
// Depends on mbp_pkg for the port types.
module mbp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input mbp_pkg::t_result              o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("An accepted word did not make the block busy.");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("A result word was shown while the block was busy.");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("A result word appeared without a pixel in work.");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("The result strobe stayed high for more than one cycle.");

    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_result))
        else $error("A result word carried unknown bits.");

endmodule

bind mandelbrot_membership_pixel mbp_chk u_mbp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_result    (o_result)
);
